// ----- rtl/core/moving_average_pwm_duty_core_assert.svh -----
// Assertion macros shared by the moving-average core RTL.
// Expects clk and rst_n in the scope of every use; empty when SYNTH is set.
`ifndef MOVING_AVERAGE_PWM_DUTY_CORE_ASSERT_SVH
`define MOVING_AVERAGE_PWM_DUTY_CORE_ASSERT_SVH

`ifndef SYNTH

`define MAPD_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("mapd check failed");

`define MAPD_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mapd check failed");

`define MAPD_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mapd check failed");

`else

`define MAPD_ASSERT(lbl, cond)
`define MAPD_IMPLIES(lbl, ante, cons)
`define MAPD_NEXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/core/mapd_pkg.sv -----
// Shared constants and widths for the moving-average PWM duty core.
// No dependencies; used by mapd_div and moving_average_pwm_duty_core.
package mapd_pkg;

    localparam int RING_DEPTH = 30;
    localparam int WINDOW_LEN = 5;

    localparam int RAW_W    = 16;
    localparam int MV_W     = 12;
    localparam int DUTY_W   = 7;
    localparam int PTR_W    = $clog2(RING_DEPTH);
    localparam int CNT_W    = $clog2(RING_DEPTH + 1);
    localparam int SUM_W    = MV_W + $clog2(RING_DEPTH);
    localparam int WSUM_W   = MV_W + $clog2(WINDOW_LEN + 1);

    // mv = raw * 2400 / 0xFFF0 = raw * 10 / 273
    localparam int SCALED_W    = 20;
    localparam int RECIP_W     = 20;
    localparam int SCALE_RECIP = 983280;   // floor(2^28 / 273)
    localparam int SCALE_SHIFT = 28;
    localparam int SCALE_DIV   = 273;

    // window sum / 5, exact for sums below 2^14
    localparam int WIN_RECIP_W = 14;
    localparam int WIN_RECIP   = 13108;
    localparam int WIN_SHIFT   = 16;

    // duty = (mean - 1000) / 10, exact for offsets below 1024
    localparam int DUTY_LOW_MV  = 1000;
    localparam int DUTY_HIGH_MV = 2000;
    localparam int DUTY_OFF_W   = 10;
    localparam int DUTY_RECIP_W = 10;
    localparam int DUTY_RECIP   = 820;
    localparam int DUTY_SHIFT   = 13;
    localparam int DUTY_MAX     = 100;

endpackage

// ----- rtl/core/mapd_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
// Depends on mapd_pkg for operand widths.
module mapd_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mapd_pkg::SUM_W-1:0]  dividend,
    input  logic [mapd_pkg::CNT_W-1:0]  divisor,
    output logic                        busy,
    output logic [mapd_pkg::SUM_W-1:0]  quotient
);
    import mapd_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  div_reg;

    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              fits;

    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = (trial >= {1'b0, div_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(SUM_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
            // partial remainder stays below the divisor
            rem_reg <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/core/moving_average_pwm_duty_core.sv -----
// Moving-average filter top: ADC scaling, 30-entry sample ring, means and PWM duty.
// Depends on mapd_pkg, mapd_div and moving_average_pwm_duty_core_assert.svh.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_ready  | raw_sample
//  out      | out_valid / out_ready| latest_mv, window_mean_mv, duty_percent,
//           |                      | overall_mean_mv
//
// While fewer than 5 samples are held an item yields no result; otherwise the walk makes
// one ring read per cycle over every held entry, and the serial divider then forms the
// overall mean from the running sum and the fill count.
// Reset clears pointer, fill count and control; the ring needs no clearing pass.
// A result waits in the output register; the next item is taken meanwhile and stalls
// only when its own result is ready before the previous one was taken.
`include "moving_average_pwm_duty_core_assert.svh"

module moving_average_pwm_duty_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [mapd_pkg::RAW_W-1:0]  raw_sample,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [mapd_pkg::MV_W-1:0]   latest_mv,
    output logic [mapd_pkg::MV_W-1:0]   window_mean_mv,
    output logic [mapd_pkg::DUTY_W-1:0] duty_percent,
    output logic [mapd_pkg::MV_W-1:0]   overall_mean_mv
);
    import mapd_pkg::*;

    localparam int PROD_W  = SCALED_W + RECIP_W;
    localparam int BACK_W  = MV_W + 9;
    localparam int DIST_W  = PTR_W + 1;
    localparam int WPROD_W = WSUM_W + WIN_RECIP_W;
    localparam int DPROD_W = DUTY_OFF_W + DUTY_RECIP_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_FIX,
        ST_WALK,
        ST_DRAIN,
        ST_DIVIDE,
        ST_DUTY,
        ST_WAIT
    } state_t;

    state_t              state_reg;
    logic [PTR_W-1:0]    wp_reg;
    logic [CNT_W-1:0]    fill_reg;
    logic [PTR_W-1:0]    rd_idx_reg;
    logic                rd_en_reg;
    logic                rd_win_reg;
    logic [PTR_W-1:0]    win_start_reg;
    logic                out_valid_reg;

    logic [SCALED_W-1:0] scaled_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [MV_W-1:0]     mv_reg;
    logic [SUM_W-1:0]    osum_reg;
    logic [WSUM_W-1:0]   wsum_reg;
    logic [MV_W-1:0]     wmean_reg;
    logic [DUTY_W-1:0]   duty_reg;
    logic [MV_W-1:0]     out_latest_reg;
    logic [MV_W-1:0]     out_wmean_reg;
    logic [DUTY_W-1:0]   out_duty_reg;
    logic [MV_W-1:0]     out_omean_reg;

    logic [MV_W-1:0]     sample_ring [RING_DEPTH];
    logic [MV_W-1:0]     rd_data_reg;

    logic                in_accept;
    logic [SCALED_W-1:0] scaled;
    logic [MV_W-1:0]     mv_est;
    logic [BACK_W-1:0]   mv_back;
    logic [SCALED_W-1:0] mv_rem;
    logic [MV_W-1:0]     mv_fix;
    logic                ring_we;
    logic [PTR_W-1:0]    wp_next;
    logic [CNT_W-1:0]    fill_next;
    logic [PTR_W-1:0]    win_start_next;
    logic [DIST_W-1:0]   win_dist;
    logic                in_win;
    logic                rd_last;
    logic [WPROD_W-1:0]  wprod;
    logic [DUTY_OFF_W-1:0] duty_off;
    logic [DPROD_W-1:0]  dprod;
    logic                div_start;
    logic                div_busy;
    logic [SUM_W-1:0]    div_quo;
    logic                load_out;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;

    // raw * 10 by shift-add
    assign scaled = SCALED_W'({raw_sample, 3'b000}) + SCALED_W'({raw_sample, 1'b0});

    // reciprocal estimate is low by at most one
    assign mv_est  = prod_reg[SCALE_SHIFT +: MV_W];
    assign mv_back = BACK_W'(mv_est) * BACK_W'(SCALE_DIV);
    assign mv_rem  = scaled_reg - mv_back[SCALED_W-1:0];
    assign mv_fix  = (mv_rem >= SCALED_W'(SCALE_DIV)) ? mv_est + 1'b1 : mv_est;

    assign ring_we   = (state_reg == ST_FIX);
    assign wp_next   = (wp_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign fill_next = (fill_reg == CNT_W'(RING_DEPTH)) ? fill_reg : fill_reg + 1'b1;
    assign win_start_next = (wp_next >= PTR_W'(WINDOW_LEN))
                          ? wp_next - PTR_W'(WINDOW_LEN)
                          : wp_next + PTR_W'(RING_DEPTH - WINDOW_LEN);

    // ring distance from the oldest window entry
    assign win_dist = (rd_idx_reg >= win_start_reg)
                    ? DIST_W'(rd_idx_reg - win_start_reg)
                    : DIST_W'(rd_idx_reg) + DIST_W'(RING_DEPTH) - DIST_W'(win_start_reg);
    assign in_win  = (win_dist < DIST_W'(WINDOW_LEN));
    assign rd_last = (rd_idx_reg == PTR_W'(fill_reg - 1'b1));

    assign wprod    = WPROD_W'(wsum_reg) * WPROD_W'(WIN_RECIP);
    assign duty_off = DUTY_OFF_W'(wmean_reg - MV_W'(DUTY_LOW_MV));
    assign dprod    = DPROD_W'(duty_off) * DPROD_W'(DUTY_RECIP);

    assign div_start = (state_reg == ST_DIVIDE);
    assign load_out  = (state_reg == ST_WAIT) && !div_busy && (!out_valid_reg || out_ready);

    mapd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (osum_reg),
        .divisor  (fill_reg),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // sample ring: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            sample_ring[wp_reg] <= mv_fix;
        end
        if (state_reg == ST_WALK)
        begin
            rd_data_reg <= sample_ring[rd_idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            fill_reg      <= '0;
            rd_idx_reg    <= '0;
            rd_en_reg     <= 1'b0;
            rd_win_reg    <= 1'b0;
            win_start_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !load_out)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE:
                begin
                    state_reg <= ST_FIX;
                end
                ST_FIX:
                begin
                    wp_reg        <= wp_next;
                    fill_reg      <= fill_next;
                    win_start_reg <= win_start_next;
                    rd_idx_reg    <= '0;
                    if (fill_next < CNT_W'(WINDOW_LEN))
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_WALK;
                    end
                end
                ST_WALK:
                begin
                    rd_en_reg  <= 1'b1;
                    rd_win_reg <= in_win;
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                    if (rd_last)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    rd_en_reg  <= 1'b0;
                    rd_win_reg <= 1'b0;
                    state_reg  <= ST_DIVIDE;
                end
                ST_DIVIDE:
                begin
                    state_reg <= ST_DUTY;
                end
                ST_DUTY:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (load_out)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            scaled_reg <= scaled;
        end
        if (state_reg == ST_SCALE)
        begin
            prod_reg <= PROD_W'(scaled_reg) * PROD_W'(SCALE_RECIP);
        end
        if (state_reg == ST_FIX)
        begin
            mv_reg   <= mv_fix;
            osum_reg <= '0;
            wsum_reg <= '0;
        end
        else if (rd_en_reg)
        begin
            osum_reg <= osum_reg + SUM_W'(rd_data_reg);
            if (rd_win_reg)
            begin
                wsum_reg <= wsum_reg + WSUM_W'(rd_data_reg);
            end
        end
        if (state_reg == ST_DIVIDE)
        begin
            wmean_reg <= wprod[WIN_SHIFT +: MV_W];
        end
        if (state_reg == ST_DUTY)
        begin
            if (wmean_reg < MV_W'(DUTY_LOW_MV))
            begin
                duty_reg <= '0;
            end
            else if (wmean_reg > MV_W'(DUTY_HIGH_MV))
            begin
                duty_reg <= DUTY_W'(DUTY_MAX);
            end
            else
            begin
                duty_reg <= dprod[DUTY_SHIFT +: DUTY_W];
            end
        end
        if (load_out)
        begin
            out_latest_reg <= mv_reg;
            out_wmean_reg  <= wmean_reg;
            out_duty_reg   <= duty_reg;
            out_omean_reg  <= div_quo[MV_W-1:0];
        end
    end

    assign out_valid       = out_valid_reg;
    assign latest_mv       = out_latest_reg;
    assign window_mean_mv  = out_wmean_reg;
    assign duty_percent    = out_duty_reg;
    assign overall_mean_mv = out_omean_reg;

    `MAPD_ASSERT(a_fill_bound, fill_reg <= CNT_W'(RING_DEPTH))
    `MAPD_ASSERT(a_wp_bound, wp_reg < PTR_W'(RING_DEPTH))
    `MAPD_IMPLIES(a_load_needs_window, load_out, fill_reg >= CNT_W'(WINDOW_LEN))
    `MAPD_IMPLIES(a_read_in_walk, rd_en_reg, state_reg == ST_WALK || state_reg == ST_DRAIN)
    `MAPD_IMPLIES(a_walk_in_fill, state_reg == ST_WALK, rd_idx_reg < PTR_W'(fill_reg))
    `MAPD_NEXT(a_div_runs, div_start, div_busy)

endmodule
